// ----- rtl/tbo_pkg.sv -----
// Shared types and constants for the time bar OHLCV aggregator.
`timescale 1ns / 1ps

package tbo_pkg;

  // Field widths.
  localparam int unsigned TS_W   = 48;
  localparam int unsigned PX_W   = 32;
  localparam int unsigned QTY_W  = 32;
  localparam int unsigned VOL_W  = 48;
  localparam int unsigned DOL_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned IV_W   = 40;
  localparam int unsigned VWAP_W = 32;
  localparam int unsigned CMD_W  = 2;

  // Packed stream widths.
  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 448;

  // Shared divider: 64-bit dividend, 48-bit divisor, one quotient bit per cycle.
  localparam int unsigned DIV_N_W  = 64;
  localparam int unsigned DIV_D_W  = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic [IV_W-1:0] IV_RESET = IV_W'(60000);

  // Command codes carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_TRADE = 2'd0,
    CMD_QUOTE = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic div_start;
    logic div_vwap;
    logic start_cap;
    logic out_load;
    logic bar_update;
  } tbo_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_event;
    logic flush_go;
    logic need_roll;
    logic div_done;
    logic out_free;
  } tbo_sts_t;

endpackage

// ----- rtl/tbo_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tbo_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tbo_pkg::DIV_N_W-1:0]    dividend_i,
  input  logic [tbo_pkg::DIV_D_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [tbo_pkg::DIV_N_W-1:0]    quotient_o,
  output logic [tbo_pkg::DIV_D_W-1:0]    remainder_o
);
  import tbo_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   dsr_q, dsr_d;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_N_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = (shifted >= {1'b0, dsr_q});
    busy_d  = busy_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = DIV_CNT_W'(DIV_N_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_N_W-2:0], ge};
      rem_d = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // A started division runs its full count before it reports done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q && (cnt_q == DIV_CNT_W'(DIV_N_W - 1)))
    else $error("divider did not start cleanly");

  // The last step always raises done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && (cnt_q == '0)) |=> done_q && !busy_q)
    else $error("divider missed its done flag");

endmodule

// ----- rtl/tbo_dp.sv -----
// Datapath: input request register, bar state, shared divider and result register.
`timescale 1ns / 1ps

module tbo_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tbo_pkg::tbo_ctl_t                  ctl_i,
  output tbo_pkg::tbo_sts_t                  sts_o,
  input  logic                               cfg_valid_i,
  input  logic [tbo_pkg::IV_W-1:0]           cfg_data_i,
  input  logic [tbo_pkg::CMD_W-1:0]          in_cmd_i,
  input  logic [tbo_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tbo_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                               out_quote_o
);
  import tbo_pkg::*;

  // Captured request.
  cmd_e              cmd_q;
  logic [TS_W-1:0]   ts_q;
  logic [PX_W-1:0]   price_q;
  logic [QTY_W-1:0]  qty_q;
  logic              maker_q;
  logic [PX_W-1:0]   bid_q;
  logic [PX_W-1:0]   ask_q;
  logic [DOL_W-1:0]  prod_q;

  // Configuration.
  logic [IV_W-1:0]   interval_q;
  logic [IV_W-1:0]   iv_eff;

  // Bar state.
  logic              bar_open_q;
  logic [TS_W-1:0]   bar_start_q, bar_end_q, start_q;
  logic [PX_W-1:0]   open_q, high_q, low_q, close_q;
  logic [VOL_W-1:0]  volume_q, buy_q;
  logic [DOL_W-1:0]  dollar_q;
  logic [CNT_W-1:0]  count_q;
  logic              quote_q;

  // Result register.
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   out_quote_q;

  // Divider hookup.
  logic [DIV_N_W-1:0] div_dividend, div_quo;
  logic [DIV_D_W-1:0] div_divisor, div_rem;
  logic               div_done;

  // Update logic.
  logic [TS_W-1:0]   start_calc;
  logic              roll;
  logic [PX_W:0]     mid_sum;
  logic [PX_W-1:0]   px;
  logic [CNT_W-1:0]  cnt_base;
  logic [VOL_W-1:0]  vol_base, buy_base;
  logic [DOL_W-1:0]  dol_base;
  logic [VOL_W:0]    vol_sum, buy_sum;
  logic [DOL_W:0]    dol_sum;
  logic [VWAP_W-1:0] vwap;

  // Capture the request; the trade product is registered from the captured price and quantity.
  always_ff @(posedge clk_i) begin
    if (ctl_i.in_load) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      ts_q    <= in_data_i[47:0];
      price_q <= in_data_i[79:48];
      qty_q   <= in_data_i[111:80];
      maker_q <= in_data_i[112];
      bid_q   <= in_data_i[144:113];
      ask_q   <= in_data_i[176:145];
    end
    prod_q <= DOL_W'(price_q) * DOL_W'(qty_q);
  end

  // Interval register; zero acts as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IV_RESET;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end
  assign iv_eff = (interval_q == '0) ? IV_W'(1) : interval_q;

  // The divider floors the timestamp or forms the volume-weighted price.
  assign div_dividend = ctl_i.div_vwap ? dollar_q : DIV_N_W'(ts_q);
  assign div_divisor  = ctl_i.div_vwap ? volume_q : DIV_D_W'(iv_eff);

  tbo_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctl_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Bar start is the timestamp less its remainder.
  assign start_calc = ts_q - div_rem;

  // Event update values.
  always_comb begin
    roll     = !bar_open_q || (start_q != bar_start_q);
    mid_sum  = {1'b0, bid_q} + {1'b0, ask_q};
    px       = (cmd_q == CMD_TRADE) ? price_q : mid_sum[PX_W:1];
    cnt_base = roll ? '0 : count_q;
    vol_base = roll ? '0 : volume_q;
    buy_base = roll ? '0 : buy_q;
    dol_base = roll ? '0 : dollar_q;
    vol_sum  = {1'b0, vol_base} + (VOL_W+1)'(qty_q);
    buy_sum  = {1'b0, buy_base} + (VOL_W+1)'(qty_q);
    dol_sum  = {1'b0, dol_base} + {1'b0, prod_q};
  end

  // Bar control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_open_q <= 1'b0;
      count_q    <= '0;
    end else if (ctl_i.bar_update) begin
      bar_open_q <= 1'b1;
      count_q    <= (cnt_base == '1) ? cnt_base : cnt_base + CNT_W'(1);
    end
  end

  // Bar payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start_cap) begin
      start_q <= start_calc;
    end
    if (ctl_i.bar_update) begin
      bar_end_q <= ts_q;
      if (roll) begin
        bar_start_q <= start_q;
        quote_q     <= (cmd_q == CMD_QUOTE);
      end
      if (cnt_base == '0) begin
        open_q  <= px;
        high_q  <= px;
        low_q   <= px;
        close_q <= px;
      end else begin
        if (px > high_q) high_q <= px;
        if (px < low_q)  low_q  <= px;
        close_q <= px;
      end
      if (cmd_q == CMD_TRADE) begin
        volume_q <= vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
        buy_q    <= maker_q ? buy_base : (buy_sum[VOL_W] ? '1 : buy_sum[VOL_W-1:0]);
        dollar_q <= dol_sum[DOL_W] ? '1 : dol_sum[DOL_W-1:0];
      end else begin
        volume_q <= vol_base;
        buy_q    <= buy_base;
        dollar_q <= dol_base;
      end
    end
  end

  // Quotient clipped to the price width; no volume gives zero.
  always_comb begin
    if (volume_q == '0) begin
      vwap = '0;
    end else if (div_quo[DIV_N_W-1:VWAP_W] != '0) begin
      vwap = '1;
    end else begin
      vwap = div_quo[VWAP_W-1:0];
    end
  end

  // Result register; it is reloaded only once the previous result has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_data_q  <= {count_q, vwap, dollar_q, buy_q, volume_q,
                      close_q, low_q, high_q, open_q, bar_end_q, bar_start_q};
      out_quote_q <= quote_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_quote_o = out_quote_q;

  // Status to the controller.
  always_comb begin
    sts_o.is_event  = (cmd_q == CMD_TRADE) || (cmd_q == CMD_QUOTE);
    sts_o.flush_go  = (cmd_q == CMD_FLUSH) && bar_open_q && (count_q != '0);
    sts_o.need_roll = bar_open_q && (start_calc != bar_start_q);
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // After an event update the bar is open and holds at least one event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.bar_update |=> bar_open_q && (count_q != '0))
    else $error("bar update left an empty bar");

endmodule

// ----- rtl/tbo_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module tbo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output tbo_pkg::tbo_ctl_t  ctl_o,
  input  tbo_pkg::tbo_sts_t  sts_i
);
  import tbo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_TS_DIV,
    ST_CHECK,
    ST_VW_DIV,
    ST_EMIT,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;

  // Command decode and next state.
  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.in_load = in_valid_i;
        if (in_valid_i) state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (sts_i.is_event) begin
          ctl_o.div_start = 1'b1;
          state_d = ST_TS_DIV;
        end else if (sts_i.flush_go) begin
          ctl_o.div_start = 1'b1;
          ctl_o.div_vwap  = 1'b1;
          state_d = ST_VW_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TS_DIV: begin
        if (sts_i.div_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        ctl_o.start_cap = 1'b1;
        if (sts_i.need_roll) begin
          ctl_o.div_start = 1'b1;
          ctl_o.div_vwap  = 1'b1;
          state_d = ST_VW_DIV;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_VW_DIV: begin
        ctl_o.div_vwap = 1'b1;
        if (sts_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        ctl_o.div_vwap = 1'b1;
        ctl_o.out_load = sts_i.out_free;
        if (sts_i.out_free) state_d = sts_i.is_event ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        ctl_o.bar_update = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> sts_i.out_free)
    else $error("result register overwritten");

  // The bar is only updated after the divider has settled its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.bar_update |-> ($past(state_q) == ST_CHECK) || ($past(state_q) == ST_EMIT))
    else $error("bar update out of sequence");

endmodule

// ----- rtl/time_bar_ohlcv_aggregator.sv -----
// Top level of the time bar OHLCV aggregator.
`timescale 1ns / 1ps

// Usage:
// Trade, quote and flush requests arrive on the s_axis channel, the command in
// tuser. Finished bars leave on the m_axis channel with the quote-bar flag in
// tuser. The bar interval is to be written on the cfg channel only while the
// block is idle; the block does not enforce this, and cfg_ready_o is always high.
// One request is handled at a time. A trade or quote that stays in the open bar
// passes once through the serial divider, which floors the timestamp to the
// interval; one that closes the bar then uses the same divider to form the
// bar's VWAP before the bar is emitted. A flush that emits uses it for the VWAP
// only, and one that does not emit needs no division. A result is loaded into the
// result register after the divider raises done, once the register is free.
// Reset clears the bar, loads an interval of 60000 ms and empties the result
// register. When the receiver stalls, a finished bar waits in the result
// register and the block holds the next emitting request until it is taken.
module time_bar_ohlcv_aggregator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write: interval in ms.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbo_pkg::IV_W-1:0]          cfg_data_i,
  // Requests.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: timestamp[47:0], price[79:48], quantity[111:80], buyer_is_maker[112],
  // bid_price[144:113], ask_price[176:145], zero padding[183:177].
  input  logic [tbo_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: cmd[1:0].
  input  logic [tbo_pkg::CMD_W-1:0]         s_axis_tuser,
  // Finished bars.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: start_time[47:0], end_time[95:48], open_price[127:96],
  // high_price[159:128], low_price[191:160], close_price[223:192],
  // total_volume[271:224], taker_buy_volume[319:272], traded_value[383:320],
  // vwap[415:384], event_count[447:416].
  output logic [tbo_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: quote_bar[0].
  output logic                              m_axis_tuser
);
  import tbo_pkg::*;

  tbo_ctl_t ctl;
  tbo_sts_t sts;

  // Configuration is taken at any time.
  assign cfg_ready_o = 1'b1;

  tbo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  tbo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_quote_o (m_axis_tuser)
  );

endmodule
